>>> src/dlph_pkg.sv
`timescale 1ns / 1ps
// Delay-line position histogrammer: shared package.
// Holds field widths, codes, item types and divider interface types; no dependencies.

package dlph_pkg;

   localparam int TIME_BITS  = 16;
   localparam int SCALE_BITS = 8;
   localparam int DIFF_BITS  = TIME_BITS + 1;
   localparam int SUM_BITS   = TIME_BITS + 2;
   localparam int NUM_BITS   = TIME_BITS + SCALE_BITS;
   localparam int DEN_BITS   = TIME_BITS + 1;
   localparam int POS_BITS   = NUM_BITS + 2;

   localparam int X_BINS_DEFAULT     = 160;
   localparam int Y_BINS_DEFAULT     = 60;
   localparam int COUNT_BITS_DEFAULT = 32;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_SCALE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_SCALE = 1'b1;

   localparam logic [SCALE_BITS-1:0] X_SCALE_RESET = 8'd80;
   localparam logic [SCALE_BITS-1:0] Y_SCALE_RESET = 8'd30;

   localparam logic [4:0] HIT_ALL = 5'h1F;

   localparam logic [2:0] STATUS_COUNTED    = 3'd0;
   localparam logic [2:0] STATUS_MISSING    = 3'd1;
   localparam logic [2:0] STATUS_ZERO_SUM   = 3'd2;
   localparam logic [2:0] STATUS_OUTSIDE    = 3'd3;
   localparam logic [2:0] STATUS_READ_REPLY = 3'd4;

   typedef struct packed {
      logic                 action;
      logic [4:0]           hit_mask;
      logic [TIME_BITS-1:0] anode_time;
      logic [TIME_BITS-1:0] right_time;
      logic [TIME_BITS-1:0] left_time;
      logic [TIME_BITS-1:0] top_time;
      logic [TIME_BITS-1:0] bottom_time;
      logic [7:0]           read_column;
      logic [5:0]           read_row;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  column;
      logic [5:0]  row;
      logic [31:0] cell_count;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] dividend;
      logic [DEN_BITS-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [NUM_BITS-1:0] quotient;
      logic                rem_nz;
   } div_res_type;

endpackage

>>> src/dlph_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on dlph_pkg for widths and the command/result structs.

module dlph_div (
   input  logic                  clock,
   input  logic                  reset,
   input  dlph_pkg::div_cmd_type cmd,
   output dlph_pkg::div_res_type res
);

   localparam int NUM_BITS = dlph_pkg::NUM_BITS;
   localparam int DEN_BITS = dlph_pkg::DEN_BITS;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;

   logic [DEN_BITS:0]   shifted;
   logic [DEN_BITS:0]   trial;

   assign shifted = {rem_ff, quo_ff[NUM_BITS-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         run_in = 1'b1;
         cnt_in = CNT_BITS'(NUM_BITS);
         quo_in = cmd.dividend;
         rem_in = '0;
         den_in = cmd.divisor;
      end else if (run_ff) begin
         if (!trial[DEN_BITS]) begin
            rem_in = trial[DEN_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;
   assign res.rem_nz   = |rem_ff;

endmodule

>>> src/dlph_ram.sv
`timescale 1ns / 1ps
// Histogram cell memory: one write port, one read port with registered data.
// No package dependencies.

module dlph_ram #(
   parameter int DEPTH = 9600,
   parameter int WIDTH = 32,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/delay_line_position_histogrammer.sv
`timescale 1ns / 1ps
// Delay-line position histogrammer top level: sequencer, shared divider, cell memory.
// Depends on dlph_pkg, dlph_div and dlph_ram.

// After reset the block sweeps all X_BINS*Y_BINS cells (9600 at the
// defaults) to zero, one cell per clock, and holds busy high meanwhile;
// csr writes are taken at any time. An item is taken when start is high and
// busy is low, and its single result shows on rsp_item for one cycle with
// rsp_valid; there is no backpressure, so the result must be captured then.
// A fully hit event with nonzero sums gets its result from the one shared
// 24-step divider, run once for x and once for y, via the check, multiply,
// divide, bin, address and read states. In range, reads pass check, address
// and read, and stop at address if not; rejects stop at check. Busy drops
// in the result cycle, so the next item can be taken at the edge ending it.

module delay_line_position_histogrammer #(
   parameter int X_BINS     = dlph_pkg::X_BINS_DEFAULT,
   parameter int Y_BINS     = dlph_pkg::Y_BINS_DEFAULT,
   parameter int COUNT_BITS = dlph_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  dlph_pkg::req_type                   req_item,
   output logic                                busy,
   output logic                                rsp_valid,
   output dlph_pkg::rsp_type                   rsp_item,
   input  logic                                csr_we,
   input  logic [dlph_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dlph_pkg::SCALE_BITS-1:0]     csr_wdata
);

   localparam int DEPTH      = X_BINS * Y_BINS;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int COL_BITS   = $clog2(X_BINS);
   localparam int ROW_BITS   = $clog2(Y_BINS);
   localparam int POS_BITS   = dlph_pkg::POS_BITS;
   localparam int DIFF_BITS  = dlph_pkg::DIFF_BITS;
   localparam int SUM_BITS   = dlph_pkg::SUM_BITS;
   localparam int TIME_BITS  = dlph_pkg::TIME_BITS;
   localparam int SCALE_BITS = dlph_pkg::SCALE_BITS;
   localparam int NUM_BITS   = dlph_pkg::NUM_BITS;
   localparam int DEN_BITS   = dlph_pkg::DEN_BITS;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b00_0000_0001,
      ST_IDLE  = 10'b00_0000_0010,
      ST_CHECK = 10'b00_0000_0100,
      ST_XMUL  = 10'b00_0000_1000,
      ST_XDIV  = 10'b00_0001_0000,
      ST_YMUL  = 10'b00_0010_0000,
      ST_YDIV  = 10'b00_0100_0000,
      ST_BIN   = 10'b00_1000_0000,
      ST_ADDR  = 10'b01_0000_0000,
      ST_READ  = 10'b10_0000_0000
   } state_type;

   state_type                     state_ff, state_in;
   dlph_pkg::req_type             req_ff, req_in;
   logic [SCALE_BITS-1:0]         x_scale_ff, x_scale_in;
   logic [SCALE_BITS-1:0]         y_scale_ff, y_scale_in;
   logic signed [DIFF_BITS-1:0]   xd_ff, xd_in, yd_ff, yd_in;
   logic signed [SUM_BITS-1:0]    xs_ff, xs_in, ys_ff, ys_in;
   logic                          neg_ff, neg_in;
   logic signed [POS_BITS-1:0]    col_ff, col_in, row_ff, row_in;
   logic                          in_range_ff, in_range_in;
   logic [ADDR_BITS-1:0]          clear_idx_ff, clear_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   dlph_pkg::rsp_type             rsp_ff, rsp_in;

   logic signed [DIFF_BITS-1:0]   xd_calc, yd_calc;
   logic signed [SUM_BITS-1:0]    xs_calc, ys_calc;
   logic signed [DIFF_BITS-1:0]   mul_diff, diff_abs;
   logic signed [SUM_BITS-1:0]    mul_sum, sum_abs;
   logic [SCALE_BITS-1:0]         mul_scale;
   logic [TIME_BITS-1:0]          diff_mag;
   logic                          mul_neg;
   logic [POS_BITS-1:0]           q_mag;
   logic signed [POS_BITS-1:0]    q_calc;
   logic signed [POS_BITS-1:0]    col_bin, row_bin;
   logic                          bin_ok;
   logic                          read_ok;
   logic [COL_BITS-1:0]           col_idx;
   logic [ROW_BITS-1:0]           row_idx;
   logic [ADDR_BITS-1:0]          cell_addr;
   logic [COUNT_BITS-1:0]         cell_rd, cell_inc;

   dlph_pkg::div_cmd_type         div_cmd;
   dlph_pkg::div_res_type         div_res;

   logic                          ram_we;
   logic [ADDR_BITS-1:0]          ram_waddr;
   logic [COUNT_BITS-1:0]         ram_wdata;

   // cathode delays relative to the anode; sums carry the doubled anode term
   assign xd_calc = $signed({1'b0, req_ff.left_time}) - $signed({1'b0, req_ff.right_time});
   assign yd_calc = $signed({1'b0, req_ff.bottom_time}) - $signed({1'b0, req_ff.top_time});
   assign xs_calc = $signed({2'b00, req_ff.left_time}) + $signed({2'b00, req_ff.right_time})
                  - $signed({1'b0, req_ff.anode_time, 1'b0});
   assign ys_calc = $signed({2'b00, req_ff.bottom_time}) + $signed({2'b00, req_ff.top_time})
                  - $signed({1'b0, req_ff.anode_time, 1'b0});

   // shared magnitude multiply feeding the divider
   assign mul_diff  = (state_ff == ST_XMUL) ? xd_ff : yd_ff;
   assign mul_sum   = (state_ff == ST_XMUL) ? xs_ff : ys_ff;
   assign mul_scale = (state_ff == ST_XMUL) ? x_scale_ff : y_scale_ff;
   assign diff_abs  = mul_diff[DIFF_BITS-1] ? -mul_diff : mul_diff;
   assign sum_abs   = mul_sum[SUM_BITS-1] ? -mul_sum : mul_sum;
   assign diff_mag  = diff_abs[TIME_BITS-1:0];
   assign mul_neg   = mul_diff[DIFF_BITS-1] ^ mul_sum[SUM_BITS-1];

   assign div_cmd.start    = (state_ff == ST_XMUL) || (state_ff == ST_YMUL);
   assign div_cmd.dividend = NUM_BITS'(diff_mag) * NUM_BITS'(mul_scale);
   assign div_cmd.divisor  = sum_abs[DEN_BITS-1:0];

   dlph_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // floor division: opposite signs with a remainder round one further down.
   // The signed POS_BITS-wide position is this integer floor, with no fraction bits.
   assign q_mag  = POS_BITS'(div_res.quotient) + POS_BITS'(div_res.rem_nz & neg_ff);
   assign q_calc = neg_ff ? -$signed(q_mag) : $signed(q_mag);

   assign col_bin = col_ff + $signed(POS_BITS'(X_BINS / 2));
   assign row_bin = row_ff + $signed(POS_BITS'(Y_BINS / 2));
   assign bin_ok  = !col_bin[POS_BITS-1] && (col_bin < $signed(POS_BITS'(X_BINS)))
                 && !row_bin[POS_BITS-1] && (row_bin < $signed(POS_BITS'(Y_BINS)));
   assign read_ok = (POS_BITS'(req_ff.read_column) < POS_BITS'(X_BINS))
                 && (POS_BITS'(req_ff.read_row) < POS_BITS'(Y_BINS));

   assign col_idx   = col_ff[COL_BITS-1:0];
   assign row_idx   = row_ff[ROW_BITS-1:0];
   assign cell_addr = ADDR_BITS'(row_idx) * ADDR_BITS'(X_BINS) + ADDR_BITS'(col_idx);
   assign cell_inc  = (cell_rd == '1) ? cell_rd : cell_rd + COUNT_BITS'(1);

   assign ram_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_READ) && !req_ff.action);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clear_idx_ff : cell_addr;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : cell_inc;

   dlph_ram #(
      .DEPTH     (DEPTH),
      .WIDTH     (COUNT_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cell_addr),
      .rd_data (cell_rd)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      xd_in        = xd_ff;
      xs_in        = xs_ff;
      yd_in        = yd_ff;
      ys_in        = ys_ff;
      neg_in       = neg_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      in_range_in  = in_range_ff;
      clear_idx_in = clear_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_idx_in = clear_idx_ff + ADDR_BITS'(1);
            if (clear_idx_ff == ADDR_BITS'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (req_ff.action) begin
               col_in      = $signed(POS_BITS'(req_ff.read_column));
               row_in      = $signed(POS_BITS'(req_ff.read_row));
               in_range_in = read_ok;
               state_in    = ST_ADDR;
            end else if (req_ff.hit_mask != dlph_pkg::HIT_ALL) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.status = dlph_pkg::STATUS_MISSING;
               state_in      = ST_IDLE;
            end else if ((xs_calc == '0) || (ys_calc == '0)) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.status = dlph_pkg::STATUS_ZERO_SUM;
               state_in      = ST_IDLE;
            end else begin
               xd_in    = xd_calc;
               xs_in    = xs_calc;
               yd_in    = yd_calc;
               ys_in    = ys_calc;
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: begin
            neg_in   = mul_neg;
            state_in = ST_XDIV;
         end
         ST_XDIV: begin
            if (div_res.done) begin
               col_in   = q_calc;
               state_in = ST_YMUL;
            end
         end
         ST_YMUL: begin
            neg_in   = mul_neg;
            state_in = ST_YDIV;
         end
         ST_YDIV: begin
            if (div_res.done) begin
               row_in   = q_calc;
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            col_in      = col_bin;
            row_in      = row_bin;
            in_range_in = bin_ok;
            state_in    = ST_ADDR;
         end
         ST_ADDR: begin
            if (in_range_ff) begin
               state_in = ST_READ;
            end else begin
               rsp_valid_in = 1'b1;
               if (req_ff.action) begin
                  rsp_in.status     = dlph_pkg::STATUS_READ_REPLY;
                  rsp_in.column     = col_ff[7:0];
                  rsp_in.row        = row_ff[5:0];
                  rsp_in.cell_count = '0;
               end else begin
                  rsp_in        = '0;
                  rsp_in.status = dlph_pkg::STATUS_OUTSIDE;
               end
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_in.column = col_ff[7:0];
            rsp_in.row    = row_ff[5:0];
            if (req_ff.action) begin
               rsp_in.status     = dlph_pkg::STATUS_READ_REPLY;
               rsp_in.cell_count = 32'(cell_rd);
            end else begin
               rsp_in.status     = dlph_pkg::STATUS_COUNTED;
               rsp_in.cell_count = 32'(cell_inc);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      x_scale_in = x_scale_ff;
      y_scale_in = y_scale_ff;
      if (csr_we) begin
         case (csr_index)
            dlph_pkg::CSR_X_SCALE: x_scale_in = csr_wdata;
            dlph_pkg::CSR_Y_SCALE: y_scale_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         x_scale_ff   <= dlph_pkg::X_SCALE_RESET;
         y_scale_ff   <= dlph_pkg::Y_SCALE_RESET;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         x_scale_ff   <= x_scale_in;
         y_scale_ff   <= y_scale_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      xd_ff       <= xd_in;
      xs_ff       <= xs_in;
      yd_ff       <= yd_in;
      ys_ff       <= ys_in;
      neg_ff      <= neg_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without an item in work");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> ((state_ff == ST_XDIV) || (state_ff == ST_YDIV)))
      else $error("divider finished outside a divide wait");
`endif

endmodule
